[rtl/core/dtm_pkg.sv]
// package for the one-mismatch tag matcher
// types, command codes and constants shared by the cell chain, resolver and top level
// no dependencies

package dtm_pkg;

    // command codes carried in the input beat
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam int unsigned TAG_W   = 16;
    localparam int unsigned OWNER_W = 6;

    // low bit of every 2-bit base
    localparam logic [TAG_W-1:0] BASE_LOW_BITS = 16'h5555;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [TAG_W-1:0]   tag_code;
        logic [OWNER_W-1:0] entry_owner;
        logic               exact_only;
    } t_in;

    typedef struct packed {
        logic [OWNER_W-1:0] sample_hit;
        logic               ambiguous;
        logic               table_full;
    } t_out;

    // lookup token handed from cell to cell
    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic               mism;
        logic               exact;
        logic [OWNER_W-1:0] hit;
    } t_tok;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

endpackage

[rtl/core/dtm_cell.sv]
// one table cell: holds a tag entry and its owner, updates the passing lookup token
// depends on dtm_pkg

module dtm_cell #(
    parameter int unsigned MAX_SAMPLES = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [dtm_pkg::TAG_W-1:0]    i_code,
    input  logic [dtm_pkg::OWNER_W-1:0]  i_owner,
    input  logic                         i_active,
    input  dtm_pkg::t_tok                i_tok,
    input  logic [MAX_SAMPLES-1:0]       i_mask,
    output dtm_pkg::t_tok                o_tok,
    output logic [MAX_SAMPLES-1:0]       o_mask
);

    logic [dtm_pkg::TAG_W-1:0]   r_code;
    logic [dtm_pkg::OWNER_W-1:0] r_owner;
    dtm_pkg::t_tok               r_tok;
    dtm_pkg::t_tok               n_tok;
    logic [MAX_SAMPLES-1:0]      r_mask;
    logic [MAX_SAMPLES-1:0]      n_mask;
    logic [dtm_pkg::TAG_W-1:0]   w_x;
    logic [dtm_pkg::TAG_W-1:0]   w_d;
    logic                        w_dist0;
    logic                        w_dist1;

    // per-base difference bits, one per base at its low bit
    assign w_x     = r_code ^ i_tok.tag;
    assign w_d     = (w_x | (w_x >> 1)) & dtm_pkg::BASE_LOW_BITS;
    assign w_dist0 = (w_d == '0);
    assign w_dist1 = !w_dist0 && ((w_d & (w_d - 1'b1)) == '0);

    always_comb begin
        n_tok  = i_tok;
        n_mask = i_mask;
        if (i_tok.valid && i_active && !i_tok.exact) begin
            if (w_dist0) begin
                n_tok.exact = 1'b1;
                n_tok.hit   = r_owner;
            end else if (i_tok.mism && w_dist1) begin
                // owners outside 1..MAX_SAMPLES never match a bit
                for (int j = 0; j < MAX_SAMPLES; j++) begin
                    if (r_owner == dtm_pkg::OWNER_W'(j + 1)) begin
                        n_mask[j] = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_code  <= i_code;
            r_owner <= i_owner;
        end
    end

    // only the valid bit is reset, the rest travels with it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.tag   <= n_tok.tag;
        r_tok.mism  <= n_tok.mism;
        r_tok.exact <= n_tok.exact;
        r_tok.hit   <= n_tok.hit;
        r_mask      <= n_mask;
    end

    assign o_tok  = r_tok;
    assign o_mask = r_mask;

endmodule

[rtl/core/dtm_resolve.sv]
// final decision on a lookup token leaving the cell chain
// depends on dtm_pkg

module dtm_resolve #(
    parameter int unsigned MAX_SAMPLES = 32
) (
    input  dtm_pkg::t_tok          i_tok,
    input  logic [MAX_SAMPLES-1:0] i_mask,
    output dtm_pkg::t_out          o_res
);

    logic                        w_multi;
    logic [dtm_pkg::OWNER_W-1:0] w_enc;

    assign w_multi = |(i_mask & (i_mask - 1'b1));

    always_comb begin
        w_enc = '0;
        for (int j = 0; j < MAX_SAMPLES; j++) begin
            if (i_mask[j]) begin
                w_enc = w_enc | dtm_pkg::OWNER_W'(j + 1);
            end
        end
    end

    always_comb begin
        o_res = '0;
        priority if (i_tok.exact) begin
            o_res.sample_hit = i_tok.hit;
        end else if (w_multi) begin
            o_res.ambiguous = 1'b1;
        end else begin
            // single owner or empty mask (encodes to zero)
            o_res.sample_hit = w_enc;
        end
    end

endmodule

[rtl/core/dna_tag_one_mismatch_matcher.sv]
// top level of the one-mismatch sample tag matcher
// holds the cell chain, entry counter, control fsm and output register
// depends on dtm_pkg, dtm_cell, dtm_resolve
//
// channel   signals                         width            beat
// in        i_valid / o_ready / i_data      t_in   (25 b)    cmd, tag, owner, exact_only
// out       o_valid / i_ready / o_data      t_out  (8 b)     hit, ambiguous, full flag
// cfg       i_cfg_we / i_cfg_wdata          1 b              allow_mismatch
//
// load, clear and unused commands answer in the cycle after the input beat
// a lookup token walks the chain one cell per cycle; r_res holds its result
// one item is in work at a time; input is taken again once the fsm is idle
// output register holds a result while i_ready is low; input waits until it is taken
// synchronous active-low reset empties the table and sets allow_mismatch

module dna_tag_one_mismatch_matcher #(
    parameter int unsigned TABLE_ENTRIES = 256,
    parameter int unsigned MAX_SAMPLES   = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  dtm_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output dtm_pkg::t_out o_data,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata
);

    localparam int unsigned USED_W = $clog2(TABLE_ENTRIES + 1);

    dtm_pkg::t_state        r_state;
    dtm_pkg::t_state        n_state;
    logic [USED_W-1:0]      r_used;
    logic [USED_W-1:0]      n_used;
    logic                   r_allow_mismatch;
    logic                   r_out_valid;
    logic                   n_out_valid;
    dtm_pkg::t_out          r_out;
    dtm_pkg::t_out          n_out;
    dtm_pkg::t_out          r_res;
    dtm_pkg::t_out          w_res;

    logic                   w_accept;
    logic                   w_full;
    logic                   w_load;
    logic                   w_out_free;

    // chain links: index 0 is the injected token, index g+1 leaves cell g
    dtm_pkg::t_tok          w_tok  [TABLE_ENTRIES+1];
    logic [MAX_SAMPLES-1:0] w_mask [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] w_valids;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_ready    = (r_state == dtm_pkg::ST_IDLE) && w_out_free;
    assign w_accept   = i_valid && o_ready;
    assign w_full     = (r_used == USED_W'(TABLE_ENTRIES));
    assign w_load     = w_accept && (i_data.cmd == dtm_pkg::CMD_LOAD) && !w_full;

    // token injection into the first cell
    assign w_tok[0]  = '{valid: w_accept && (i_data.cmd == dtm_pkg::CMD_LOOKUP),
                         tag:   i_data.tag_code,
                         mism:  !i_data.exact_only && r_allow_mismatch,
                         exact: 1'b0,
                         hit:   '0};
    assign w_mask[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        dtm_cell #(
            .MAX_SAMPLES (MAX_SAMPLES)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_we     (w_load && (r_used == USED_W'(g))),
            .i_code   (i_data.tag_code),
            .i_owner  (i_data.entry_owner),
            .i_active (USED_W'(g) < r_used),
            .i_tok    (w_tok[g]),
            .i_mask   (w_mask[g]),
            .o_tok    (w_tok[g+1]),
            .o_mask   (w_mask[g+1])
        );
        assign w_valids[g] = w_tok[g+1].valid;
    end

    dtm_resolve #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_resolve (
        .i_tok  (w_tok[TABLE_ENTRIES]),
        .i_mask (w_mask[TABLE_ENTRIES]),
        .o_res  (w_res)
    );

    // next state, counter and output register
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        unique case (r_state)
            dtm_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_out = '0;
                    priority if (i_data.cmd == dtm_pkg::CMD_LOOKUP) begin
                        n_state = dtm_pkg::ST_RUN;
                    end else if (i_data.cmd == dtm_pkg::CMD_LOAD) begin
                        n_out_valid      = 1'b1;
                        n_out.table_full = w_full;
                        if (!w_full) begin
                            n_used = r_used + 1'b1;
                        end
                    end else if (i_data.cmd == dtm_pkg::CMD_CLEAR) begin
                        n_out_valid = 1'b1;
                        n_used      = '0;
                    end else begin
                        // unused command: empty answer, no state change
                        n_out_valid = 1'b1;
                    end
                end
            end
            dtm_pkg::ST_RUN: begin
                if (w_tok[TABLE_ENTRIES].valid) begin
                    n_state = dtm_pkg::ST_DONE;
                end
            end
            dtm_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = dtm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dtm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= dtm_pkg::ST_IDLE;
            r_used           <= '0;
            r_out_valid      <= 1'b0;
            r_allow_mismatch <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_allow_mismatch <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (w_tok[TABLE_ENTRIES].valid) begin
            r_res <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // checks
    a_tok_exit_in_run : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[TABLE_ENTRIES].valid |-> (r_state == dtm_pkg::ST_RUN))
        else $error("lookup token left the chain outside run state");

    a_single_token : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_valids))
        else $error("more than one lookup token in the chain");

    a_used_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_inject : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_data.cmd == dtm_pkg::CMD_LOOKUP)) |=> w_tok[1].valid)
        else $error("lookup beat did not enter the first cell");

endmodule
